/* hw/rtl/assert_macros.svh */
// Assertion macros included by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Plain condition that must hold on every rising clk edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

/* hw/rtl/ffpa_pkg.sv */
// Types and constants of the first-fit partition allocator.
package ffpa_pkg;

	localparam int MAX_PARTITIONS = 16;
	localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	localparam logic [1:0] ST_ADDED     = 2'd0;
	localparam logic [1:0] ST_ALLOCATED = 2'd1;
	localparam logic [1:0] ST_NO_FIT    = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [31:0] start_addr;
		logic [31:0] amount;
	} ffpa_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] alloc_start;
		logic [31:0] alloc_end;
		logic [31:0] remaining_size;
		logic [3:0]  slot_index;
	} ffpa_res_t;

	// Priority chain link between neighboring cells.
	typedef struct packed {
		logic             taken;
		logic [IDX_W-1:0] idx;
	} ffpa_link_t;

endpackage

/* hw/rtl/first_fit_partition_allocator_unit.sv */
// Top level of the first-fit partition allocator: request register and chain of slot cells.
//
// Usage:
//   An item (kind, start_addr, amount on req) is taken at a rising edge with start
//   high and busy low. kind add appends a partition; kind allocate carves the request
//   off the first partition, in table order, that is large enough.
//   Exactly one result per item appears on res for one cycle with done high.
//   The accept edge loads the request register and raises busy for the evaluate cycle;
//   the result is registered at the end of it. No new item is taken while busy is high.
//   The evaluate cycle compares all slots in parallel and a priority chain that runs
//   through the cells picks the first fit; the chosen cell updates at the end of it.
//   The receiver cannot stall: a result not taken in its cycle is gone.
//   Reset empties the table (all slot valid flags cleared) and drops any item in
//   flight; the block accepts the next cycle. Slot contents are not reset.
module first_fit_partition_allocator_unit import ffpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ffpa_req_t req,
	output logic      done,
	output ffpa_res_t res
);

	`include "assert_macros.svh"

	ffpa_req_t  req_q;
	logic       pend_q;
	logic       done_q;
	ffpa_res_t  res_q;
	ffpa_res_t  res_none;

	ffpa_link_t link [MAX_PARTITIONS+1];
	ffpa_res_t  chain [MAX_PARTITIONS+1];
	logic [MAX_PARTITIONS-1:0] valid_vec;
	logic [MAX_PARTITIONS-1:0] hit_vec;

	assign busy = pend_q;
	assign done = done_q;
	assign res  = res_q;

	assign link[0].taken = 1'b0;
	assign link[0].idx   = '0;

	// Result when no cell claims the beat.
	always_comb begin
		res_none = '0;
		res_none.status = (req_q.kind == KIND_ALLOC) ? ST_NO_FIT : ST_FULL;
	end

	assign chain[0] = res_none;

	for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
		ffpa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pend_q),
			.req      (req_q),
			.link_in  (link[g]),
			.link_out (link[g+1]),
			.res_in   (chain[g]),
			.res_out  (chain[g+1]),
			.valid    (valid_vec[g]),
			.hit      (hit_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pend_q <= start && !pend_q;
			done_q <= pend_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !pend_q) begin
			req_q <= req;
		end
		if (pend_q) begin
			res_q <= chain[MAX_PARTITIONS];
		end
	end

	`ASSERT_CLK(a_pend_gives_done, pend_q |=> done_q, "evaluate beat did not produce a result")
	`ASSERT_ALWAYS(a_single_winner, $onehot0(hit_vec), "more than one slot claimed a beat")
	`ASSERT_CLK(a_full_means_all_valid, done_q && res_q.status == ST_FULL |-> &valid_vec,
		"table full reported with a free slot")

endmodule

/* hw/rtl/ffpa_cell.sv */
// One table slot: holds a partition and claims a request if no earlier slot has.
module ffpa_cell import ffpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  ffpa_req_t  req,
	input  ffpa_link_t link_in,
	output ffpa_link_t link_out,
	input  ffpa_res_t  res_in,
	output ffpa_res_t  res_out,
	output logic       valid,
	output logic       hit
);

	logic        valid_q;
	logic [31:0] start_q;
	logic [31:0] size_q;
	logic        fits;
	logic [31:0] new_start;
	logic [31:0] new_size;

	// Valid slots always form a prefix, so the first empty slot is the append point.
	assign fits      = (req.kind == KIND_ALLOC) ? (valid_q && (size_q >= req.amount)) : !valid_q;
	assign hit       = en && !link_in.taken && fits;
	assign new_start = start_q + req.amount;
	assign new_size  = size_q - req.amount;

	assign link_out.taken = link_in.taken || hit;
	assign link_out.idx   = link_in.idx + IDX_W'(1);
	assign valid          = valid_q;

	always_comb begin
		res_out = res_in;
		if (hit) begin
			res_out = '0;
			res_out.slot_index = 4'(link_in.idx);
			if (req.kind == KIND_ALLOC) begin
				res_out.status         = ST_ALLOCATED;
				res_out.alloc_start    = start_q;
				res_out.alloc_end      = new_start;
				res_out.remaining_size = new_size;
			end else begin
				res_out.status = ST_ADDED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hit && req.kind == KIND_ADD) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			if (req.kind == KIND_ALLOC) begin
				start_q <= new_start;
				size_q  <= new_size;
			end else begin
				start_q <= req.start_addr;
				size_q  <= req.amount;
			end
		end
	end

endmodule
